// ----- rtl/core/date_interval_index_range_query_top_macros.svh -----
// Assertion helpers for the date interval index
`ifndef DATE_INTERVAL_INDEX_RANGE_QUERY_TOP_MACROS_SVH
`define DATE_INTERVAL_INDEX_RANGE_QUERY_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define DII_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dii assertion failed");
// next-cycle implication
`define DII_ASSERT_NX(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dii assertion failed");
`else
`define DII_ASSERT(lbl, ante, cons)
`define DII_ASSERT_NX(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/dii_pkg.sv -----
`default_nettype none
package dii_pkg;

  localparam int DAY_BITS_DEF = 22;
  localparam int MAX_DOCS_DEF = 256;

  // date converter depth, capture register included
  localparam int CONV_CYCLES = 4;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_VALID   = 2'd1;
  localparam logic [1:0] OP_CREATED = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] first_year;
    logic [3:0]  first_month;
    logic [4:0]  first_day;
    logic [13:0] second_year;
    logic [3:0]  second_month;
    logic [4:0]  second_day;
    logic        second_open;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  assigned_id;
    logic [1:0]  word_index;
    logic [63:0] match_bits;
    logic        last;
  } out_item_t;

  // query token travelling down the cell row
  typedef struct packed {
    logic valid;
    logic created;
  } dii_ctl_t;

  // days before the first of the month, year starting in March
  function automatic logic [8:0] doy_base(input logic [3:0] month);
    logic [8:0] r;
    case (month)
      4'd0:    r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd13:   r = 9'd306;
      4'd14:   r = 9'd337;
      default: r = 9'd367;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dii_stream_if.sv -----
`default_nettype none
interface dii_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dii_date.sv -----
`default_nettype none
// Civil date to day count, three register stages
module dii_date import dii_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic [13:0]         year,
  input  wire logic [3:0]          month,
  input  wire logic [4:0]          day,
  output logic      [DAY_BITS-1:0] days
);

  logic signed [14:0] yr;
  logic        [27:0] era_prod;
  logic signed [6:0]  era;
  logic signed [9:0]  doy;
  logic signed [14:0] yr_s1_r;
  logic signed [6:0]  era_s1_r;
  logic signed [9:0]  doy_s1_r;

  logic signed [15:0] yr16;
  logic signed [15:0] era16;
  logic signed [15:0] yoe_w;
  logic        [8:0]  yoe_s2_r;
  logic signed [6:0]  era_s2_r;
  logic signed [9:0]  doy_s2_r;

  logic        [18:0] y365;
  logic        [15:0] y41;
  logic        [18:0] doe_u;
  logic signed [31:0] era32;
  logic signed [31:0] doy32;
  logic signed [31:0] v;
  logic [DAY_BITS-1:0] days_r;

  // stage 1: shifted year, era by reciprocal of 400, day of year
  always_comb begin
    yr       = $signed({1'b0, year}) - ((month <= 4'd2) ? 15'sd1 : 15'sd0);
    era_prod = {14'b0, yr[13:0]} * 28'd10486;
    era      = yr[14] ? -7'sd1 : $signed({1'b0, era_prod[27:22]});
    doy      = $signed({1'b0, doy_base(month)}) + $signed({5'b0, day}) - 10'sd1;
  end

  always_ff @(posedge clk) begin
    yr_s1_r  <= yr;
    era_s1_r <= era;
    doy_s1_r <= doy;
  end

  // stage 2: year of era
  always_comb begin
    yr16  = yr_s1_r;
    era16 = era_s1_r;
    yoe_w = yr16 - era16 * 16'sd400;
  end

  always_ff @(posedge clk) begin
    yoe_s2_r <= yoe_w[8:0];
    era_s2_r <= era_s1_r;
    doy_s2_r <= doy_s1_r;
  end

  // stage 3: day of era and final offset; /100 via reciprocal
  always_comb begin
    y365  = {10'b0, yoe_s2_r} * 19'd365;
    y41   = {7'b0, yoe_s2_r} * 16'd41;
    doe_u = y365 + {12'b0, yoe_s2_r[8:2]} - {15'b0, y41[15:12]};
    era32 = era_s2_r;
    doy32 = doy_s2_r;
    v     = era32 * 32'sd146097 + $signed({13'b0, doe_u}) + doy32 - 32'sd719468;
  end

  always_ff @(posedge clk) begin
    days_r <= v[DAY_BITS-1:0];
  end

  assign days = days_r;

endmodule
`default_nettype wire

// ----- rtl/core/dii_cell.sv -----
`default_nettype none
// One document slot; the query token passes one cell per cycle
module dii_cell import dii_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF,
  parameter int IDX_BITS = 8,
  parameter int CNT_BITS = 9,
  parameter int INDEX    = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [IDX_BITS-1:0] wr_id,
  input  wire logic [DAY_BITS-1:0] wr_begin,
  input  wire logic [DAY_BITS-1:0] wr_end,
  input  wire logic [CNT_BITS-1:0] doc_count,
  input  wire dii_ctl_t            ctl_in,
  input  wire logic [DAY_BITS-1:0] lo_in,
  input  wire logic [DAY_BITS-1:0] hi_in,
  output dii_ctl_t                 ctl_out,
  output logic      [DAY_BITS-1:0] lo_out,
  output logic      [DAY_BITS-1:0] hi_out,
  output logic                     hit
);

  logic [DAY_BITS-1:0] begin_r;
  logic [DAY_BITS-1:0] end_r;
  logic                hit_r;
  logic                hit_nxt;
  dii_ctl_t            ctl_r;
  logic [DAY_BITS-1:0] lo_r;
  logic [DAY_BITS-1:0] hi_r;

  // document store
  always_ff @(posedge clk) begin
    if (wr_en && (wr_id == IDX_BITS'(INDEX))) begin
      begin_r <= wr_begin;
      end_r   <= wr_end;
    end
  end

  // match test for the passing token
  always_comb begin
    if (ctl_in.created) begin
      hit_nxt = (begin_r >= lo_in) && (begin_r <= hi_in);
    end else begin
      hit_nxt = (begin_r <= hi_in) && (end_r >= lo_in);
    end
    hit_nxt = hit_nxt && (CNT_BITS'(INDEX) < doc_count);
  end

  always_ff @(posedge clk) begin
    if (ctl_in.valid) begin
      hit_r <= hit_nxt;
    end
    lo_r <= lo_in;
    hi_r <= hi_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  assign ctl_out = ctl_r;
  assign lo_out  = lo_r;
  assign hi_out  = hi_r;
  assign hit     = hit_r;

endmodule
`default_nettype wire

// ----- rtl/core/date_interval_index_range_query_top.sv -----
// Add: the two dates are converted, then one result is returned.
// Query: a token walks the row of MAX_DOCS document cells, one cell a cycle;
// the result words then follow, one word per cycle while the receiver is
// ready; one item is in flight at a time.
// Synchronous active-low reset clears the document count and control;
// document cells hold no reset value and are read only below the count.
`default_nettype none
`include "date_interval_index_range_query_top_macros.svh"
module date_interval_index_range_query_top import dii_pkg::*; #(
  parameter int DAY_BITS = DAY_BITS_DEF,
  parameter int MAX_DOCS = MAX_DOCS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  dii_stream_if.sink   in_ch,
  dii_stream_if.source out_ch
);

  localparam int IDX_BITS   = $clog2(MAX_DOCS);
  localparam int CNT_BITS   = $clog2(MAX_DOCS + 1);
  localparam int WORD_COUNT = (MAX_DOCS + 63) / 64;
  localparam int WIDX_BITS  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state_r;
  logic [1:0]           conv_cnt_r;
  in_item_t             item_r;
  logic [CNT_BITS-1:0]  doc_count_r;
  logic [WIDX_BITS-1:0] word_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [DAY_BITS-1:0]  first_days;
  logic [DAY_BITS-1:0]  second_days;
  logic                 conv_done;
  logic                 full;
  logic                 wr_en;
  logic                 inject;

  dii_ctl_t             ctl_chain [0:MAX_DOCS];
  logic [DAY_BITS-1:0]  lo_chain  [0:MAX_DOCS];
  logic [DAY_BITS-1:0]  hi_chain  [0:MAX_DOCS];
  logic [MAX_DOCS-1:0]  hits;
  logic [WORD_COUNT*64-1:0] hits_pad;

  // date converters
  dii_date #(.DAY_BITS(DAY_BITS)) u_first (
    .clk(clk), .year(item_r.first_year), .month(item_r.first_month),
    .day(item_r.first_day), .days(first_days)
  );
  dii_date #(.DAY_BITS(DAY_BITS)) u_second (
    .clk(clk), .year(item_r.second_year), .month(item_r.second_month),
    .day(item_r.second_day), .days(second_days)
  );

  assign conv_done = (state_r == S_CONV) && (conv_cnt_r == 2'(CONV_CYCLES - 1));
  assign full      = (doc_count_r >= CNT_BITS'(MAX_DOCS));
  assign wr_en     = conv_done && (item_r.opcode == OP_ADD) && !full;
  assign inject    = conv_done && (item_r.opcode != OP_ADD);

  // head of the cell row
  always_comb begin
    ctl_chain[0].valid   = inject;
    ctl_chain[0].created = (item_r.opcode == OP_CREATED);
    lo_chain[0]          = first_days;
    hi_chain[0]          = second_days;
  end

  for (genvar i = 0; i < MAX_DOCS; i++) begin : g_cell
    dii_cell #(
      .DAY_BITS(DAY_BITS), .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS), .INDEX(i)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .wr_en(wr_en), .wr_id(doc_count_r[IDX_BITS-1:0]),
      .wr_begin(first_days),
      .wr_end(item_r.second_open ? {DAY_BITS{1'b1}} : second_days),
      .doc_count(doc_count_r),
      .ctl_in(ctl_chain[i]), .lo_in(lo_chain[i]), .hi_in(hi_chain[i]),
      .ctl_out(ctl_chain[i+1]), .lo_out(lo_chain[i+1]), .hi_out(hi_chain[i+1]),
      .hit(hits[i])
    );
  end

  assign hits_pad = (WORD_COUNT*64)'(hits);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      conv_cnt_r  <= '0;
      doc_count_r <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r     <= in_ch.data;
            conv_cnt_r <= '0;
            if (in_ch.data.opcode != OP_NONE) begin
              state_r <= S_CONV;
            end
          end
        end
        S_CONV: begin
          conv_cnt_r <= conv_cnt_r + 2'd1;
          if (conv_done) begin
            if (item_r.opcode == OP_ADD) begin
              out_r.status      <= full ? ST_FULL : ST_OK;
              out_r.assigned_id <= full ? 8'd0 : 8'(doc_count_r);
              out_r.word_index  <= 2'd0;
              out_r.match_bits  <= 64'd0;
              out_r.last        <= 1'b1;
              out_valid_r       <= 1'b1;
              if (!full) begin
                doc_count_r <= doc_count_r + CNT_BITS'(1);
              end
              state_r <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ctl_chain[MAX_DOCS].valid) begin
            word_r            <= '0;
            out_r.status      <= ST_OK;
            out_r.assigned_id <= 8'd0;
            out_r.word_index  <= 2'd0;
            out_r.match_bits  <= hits_pad[63:0];
            out_r.last        <= (WORD_COUNT == 1);
            out_valid_r       <= 1'b1;
            state_r           <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (out_r.last) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              word_r           <= word_r + WIDX_BITS'(1);
              out_r.word_index <= 2'(word_r + WIDX_BITS'(1));
              out_r.match_bits <= hits_pad[{word_r + WIDX_BITS'(1), 6'b0} +: 64];
              out_r.last       <= ((word_r + WIDX_BITS'(1)) == WIDX_BITS'(WORD_COUNT - 1));
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // checks
  `DII_ASSERT(a_count_bound, 1'b1, doc_count_r <= CNT_BITS'(MAX_DOCS))
  `DII_ASSERT(a_one_in_flight, in_ch.ready, !out_ch.valid)
  `DII_ASSERT_NX(a_scan_to_out, (state_r == S_SCAN) && ctl_chain[MAX_DOCS].valid,
                 out_ch.valid && (out_ch.data.word_index == 2'd0))
  `DII_ASSERT_NX(a_full_add, conv_done && (item_r.opcode == OP_ADD) && full,
                 out_ch.data.status == ST_FULL)

endmodule
`default_nettype wire

// ----- tb/tb_date_interval_index_range_query_top.sv -----
`timescale 1ns / 1ps
module tb_date_interval_index_range_query_top;
  import dii_pkg::*;

  localparam int DAY_BITS = DAY_BITS_DEF;
  localparam int MAX_DOCS = MAX_DOCS_DEF;
  localparam int WORDS = (MAX_DOCS + 63) / 64;
  localparam logic [DAY_BITS-1:0] DAY_ALL_ONES = '1;

  logic clk;
  logic rst_n;

  dii_stream_if #(.T(in_item_t))  in_ch ();
  dii_stream_if #(.T(out_item_t)) out_ch ();

  date_interval_index_range_query_top #(
    .DAY_BITS(DAY_BITS),
    .MAX_DOCS(MAX_DOCS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // shadow of the document table
  int unsigned           doc_total;
  logic [DAY_BITS-1:0]   begin_tab [MAX_DOCS];
  logic [DAY_BITS-1:0]   end_tab [MAX_DOCS];
  out_item_t             pending_words[$];
  int                    errors;
  bit                    quiet_in;
  bit                    quiet_out;
  int                    hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // civil days-from-date, wrapped to DAY_BITS
  function automatic logic [DAY_BITS-1:0] civil_days(int y, int m, int d);
    longint yr, era, yoe, mp, doy, doe, v;
    yr = y - ((m <= 2) ? 1 : 0);
    era = (yr >= 0 ? yr : yr - 399) / 400;
    yoe = yr - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    v = era * 146097 + doe - 719468;
    return v[DAY_BITS-1:0];
  endfunction

  // update the table and queue the words an item should produce
  task automatic predict_index(input in_item_t it);
    logic [DAY_BITS-1:0] lo, hi, b;
    out_item_t r;
    int id;
    lo = civil_days(int'(it.first_year), int'(it.first_month), int'(it.first_day));
    hi = civil_days(int'(it.second_year), int'(it.second_month), int'(it.second_day));
    r = '0;
    r.last = 1'b1;
    if (it.opcode == OP_ADD) begin
      if (doc_total >= MAX_DOCS) begin
        r.status = ST_FULL;
      end else begin
        begin_tab[doc_total] = lo;
        end_tab[doc_total] = it.second_open ? DAY_ALL_ONES : hi;
        r.assigned_id = doc_total[7:0];
        doc_total++;
      end
      pending_words.insert(pending_words.size(), r);
    end else if (it.opcode != OP_NONE) begin
      for (int w = 0; w < WORDS; w++) begin
        r = '0;
        r.word_index = w[1:0];
        r.last = (w == WORDS - 1);
        for (int k = 0; k < 64; k++) begin
          id = w * 64 + k;
          if (id < doc_total) begin
            b = begin_tab[id];
            if (it.opcode == OP_VALID)
              r.match_bits[k] = (b <= hi) && (end_tab[id] >= lo);
            else
              r.match_bits[k] = (b >= lo) && (b <= hi);
          end
        end
        pending_words.insert(pending_words.size(), r);
      end
    end
  endtask

  // one beat on the input channel, with random gaps; valid stays up after
  // the beat so that the next item can follow without a gap
  task automatic send_item(input in_item_t it);
    while (!quiet_in && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_index(it);
  endtask

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.first_year = 14'($urandom_range(1960, 2060));
    it.first_month = 4'($urandom_range(1, 12));
    it.first_day = 5'($urandom_range(1, 28));
    it.second_year = 14'($urandom_range(1960, 2060));
    it.second_month = 4'($urandom_range(1, 12));
    it.second_day = 5'($urandom_range(1, 28));
    it.second_open = ($urandom_range(3) == 0);
    if ($urandom_range(9) == 0) begin
      it.first_year = 14'($urandom);
      it.first_month = 4'($urandom);
      it.first_day = 5'($urandom);
      it.second_year = 14'($urandom);
      it.second_month = 4'($urandom);
      it.second_day = 5'($urandom);
    end
    return it;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, int y1, int m1, int d1,
                                         int y2, int m2, int d2, bit open_end);
    in_item_t it;
    it.opcode = op;
    it.first_year = 14'(y1);
    it.first_month = 4'(m1);
    it.first_day = 5'(d1);
    it.second_year = 14'(y2);
    it.second_month = 4'(m2);
    it.second_day = 5'(d2);
    it.second_open = open_end;
    return it;
  endfunction

  // drop valid and wait for every queued result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // field extremes, every operation, odd dates
  task automatic test_directed();
    send_item(make_item(OP_VALID, 2000, 1, 1, 2001, 1, 1, 0));
    send_item(make_item(OP_ADD, 2000, 3, 1, 2010, 2, 28, 0));
    send_item(make_item(OP_ADD, 1969, 12, 31, 0, 1, 1, 1));
    send_item(make_item(OP_ADD, 0, 1, 1, 9999, 12, 31, 0));
    send_item(make_item(OP_ADD, 16383, 15, 31, 16383, 15, 31, 0));
    send_item(make_item(OP_ADD, 2020, 0, 0, 2020, 13, 0, 1));
    send_item(make_item(OP_ADD, 1970, 1, 1, 1970, 1, 1, 0));
    send_item(make_item(OP_VALID, 1970, 1, 1, 9999, 12, 31, 1));
    send_item(make_item(OP_CREATED, 1970, 1, 1, 9999, 12, 31, 0));
    send_item(make_item(OP_VALID, 2010, 1, 1, 2000, 1, 1, 0));
    send_item(make_item(OP_CREATED, 2010, 1, 1, 2000, 1, 1, 1));
    send_item(make_item(OP_NONE, 16383, 15, 31, 16383, 15, 31, 1));
    send_item(make_item(OP_CREATED, 0, 0, 0, 16383, 15, 31, 0));
    send_item(make_item(OP_VALID, 16383, 15, 31, 0, 0, 0, 1));
    send_item(make_item(OP_ADD, 2004, 2, 29, 2100, 2, 29, 0));
    send_item(make_item(OP_CREATED, 2004, 2, 29, 2004, 2, 29, 0));
    wait_drained();
  endtask

  // receiver stalls a long time while adds keep coming
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 12; i++) send_item(rand_item(OP_ADD));
    send_item(rand_item(OP_VALID));
    send_item(rand_item(OP_CREATED));
    wait_drained();
  endtask

  // mostly adds, queries throughout
  task automatic test_random();
    logic [1:0] op;
    for (int i = 0; i < 400; i++) begin
      quiet_in = (i >= 150 && i < 220);
      quiet_out = quiet_in;
      case ($urandom_range(19))
        0, 1, 2:    op = OP_VALID;
        3, 4:       op = OP_CREATED;
        5:          op = OP_NONE;
        default:    op = OP_ADD;
      endcase
      send_item(rand_item(op));
      if (i == 100) wait_drained();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  // fill the table, then adds must be refused
  task automatic test_full_table();
    while (doc_total < MAX_DOCS) send_item(rand_item(OP_ADD));
    for (int i = 0; i < 4; i++) send_item(rand_item(OP_ADD));
    send_item(make_item(OP_VALID, 0, 0, 0, 16383, 15, 31, 0));
    send_item(rand_item(OP_CREATED));
  endtask

  // result side: random stalls, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_out || ($urandom_range(99) >= 14);
      end
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.assigned_id !== want.assigned_id) begin
          $display("%0t: assigned_id exp %0d got %0d", $time, want.assigned_id,
                   got.assigned_id);
          errors++;
        end
        if (got.word_index !== want.word_index) begin
          $display("%0t: word_index exp %0d got %0d", $time, want.word_index,
                   got.word_index);
          errors++;
        end
        if (got.match_bits !== want.match_bits) begin
          $display("%0t: match_bits exp %h got %h", $time, want.match_bits,
                   got.match_bits);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    doc_total = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_off = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_table();
    wait_drained();
    repeat (2 * MAX_DOCS + 20) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
